>>> design/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds the operation codes, status codes and the per-step control struct.
// No dependencies; compile this file first.
package deq_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REVERSE    = 3'd4
    } deq_mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } deq_status_t;

    // Control and status of one step, passed from the pointer unit to the top.
    typedef struct packed {
        logic        wr_en;
        logic        empty;
        logic        full;
        logic        rev;
        deq_status_t status;
    } deq_op_t;

endpackage

>>> design/deq_if.sv
// Valid/ready channel interfaces for the double-ended queue.
// deq_req_if carries operations in, deq_rsp_if carries results out.
// No dependencies.
interface deq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [63:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] front_value;
    logic [63:0] back_value;
    logic [4:0]  count;
    logic        empty_res;
    logic        full_res;
    logic [1:0]  status;

    modport source (output valid, output front_value, output back_value, output count,
                    output empty_res, output full_res, output status, input ready);
    modport sink   (input valid, input front_value, input back_value, input count,
                    input empty_res, input full_res, input status, output ready);
endinterface

>>> design/deq_store.sv
// Slot memory of the double-ended queue: one write port, two registered read ports.
// A read of the entry written in the same cycle returns the new word.
// No package dependencies.
module deq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
            rd_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> design/deq_ptr.sv
// Pointer unit of the double-ended queue: head index, entry count and orientation.
// Decodes the operation, gives the write and read slots and the step's status.
// Depends on deq_pkg.
module deq_ptr #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [2:0]     mode,
    output logic [AW-1:0]  wr_addr,
    output logic [AW-1:0]  rd_low_addr,
    output logic [AW-1:0]  rd_high_addr,
    output logic [CW-1:0]  count_after,
    output deq_pkg::deq_op_t op
);
    import deq_pkg::*;

    localparam int SW = CW + 1;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rev_reg;
    logic          rev_next;
    logic          full_now;
    logic          write_en;
    deq_status_t   status;

    // Slot that lies off entries past base, with off no larger than the capacity.
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {{(SW-AW){1'b0}}, base} + {1'b0, off};
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign full_now = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        write_en   = 1'b0;
        wr_addr    = wrap(head_reg, count_reg);
        status     = STAT_OK;
        unique case (mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (full_now)
                begin
                    status = STAT_OVERFLOW;
                end
                else
                begin
                    write_en   = 1'b1;
                    count_next = count_reg + CW'(1);
                    if ((mode == MODE_PUSH_FRONT) != rev_reg)
                    begin
                        head_next = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);
                        wr_addr   = head_next;
                    end
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    status = STAT_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if ((mode == MODE_POP_FRONT) != rev_reg)
                    begin
                        head_next = wrap(head_reg, CW'(1));
                    end
                end
            end
            MODE_REVERSE:
            begin
                if (count_reg != '0)
                begin
                    rev_next = ~rev_reg;
                end
            end
            default:
            begin
                // Unused codes leave the queue as it is.
            end
        endcase
    end

    assign rd_low_addr  = head_next;
    assign rd_high_addr = wrap(head_next, (count_next == '0) ? '0 : count_next - CW'(1));
    assign count_after  = count_next;

    assign op.wr_en  = write_en;
    assign op.empty  = (count_next == '0);
    assign op.full   = (count_next == CW'(CAPACITY));
    assign op.rev    = rev_next;
    assign op.status = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (step)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

>>> design/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Instantiates deq_ptr and deq_store; uses deq_pkg and the channels of deq_if.
//
//   Channel | Direction | Carries
//   --------+-----------+------------------------------------------------------
//   req     | in        | mode, value
//   rsp     | out       | front_value, back_value, count, empty_res, full_res,
//           |           | status
//
// For an operation, the transfer cycle updates the pointers, writes the pushed
// word and issues both end reads; the response state then takes the registered
// read data into the result register once that register is free. No new request
// is taken until the response state has loaded the result of the last one.
// Reset clears the pointers, the count, the orientation and the handshake state;
// the slot memory itself is not cleared and needs no clearing pass.
// A result waiting on rsp does not block the next req transfer; only a second
// finished result waits for the result register to free up.
module double_ended_queue #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    deq_req_if.sink        req,
    deq_rsp_if.source      rsp
);
    import deq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                  req_xfer;
    logic                  res_load;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_low_addr;
    logic [AW-1:0]         rd_high_addr;
    logic [CW-1:0]         count_after;
    deq_op_t               op;
    logic [DATA_WIDTH-1:0] low_data;
    logic [DATA_WIDTH-1:0] high_data;

    // Step information held until the read data returns.
    deq_op_t               op_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW+4:0]         cnt_wide;

    // Result register.
    logic                  rsp_valid_reg;
    logic [63:0]           front_reg;
    logic [63:0]           back_reg;
    logic [4:0]            rsp_count_reg;
    logic                  empty_reg;
    logic                  full_reg;
    logic [1:0]            status_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign res_load  = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);

    deq_ptr #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ptr (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (req_xfer),
        .mode         (req.mode),
        .wr_addr      (wr_addr),
        .rd_low_addr  (rd_low_addr),
        .rd_high_addr (rd_high_addr),
        .count_after  (count_after),
        .op           (op)
    );

    deq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (req_xfer && op.wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (req.value[DATA_WIDTH-1:0]),
        .rd_en     (req_xfer),
        .rd_addr_a (rd_low_addr),
        .rd_addr_b (rd_high_addr),
        .rd_data_a (low_data),
        .rd_data_b (high_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg  <= op;
            cnt_reg <= count_after;
        end
    end

    // The count field wraps modulo 32 for large capacities.
    assign cnt_wide = (CW + 5)'(cnt_reg);

    // In normal orientation the front is the low end of the stored run.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (op_reg.empty)
            begin
                front_reg <= '0;
                back_reg  <= '0;
            end
            else if (op_reg.rev)
            begin
                front_reg <= 64'(high_data);
                back_reg  <= 64'(low_data);
            end
            else
            begin
                front_reg <= 64'(low_data);
                back_reg  <= 64'(high_data);
            end
            rsp_count_reg <= cnt_wide[4:0];
            empty_reg     <= op_reg.empty;
            full_reg      <= op_reg.full;
            status_reg    <= op_reg.status;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.front_value = front_reg;
    assign rsp.back_value  = back_reg;
    assign rsp.count       = rsp_count_reg;
    assign rsp.empty_res   = empty_reg;
    assign rsp.full_res    = full_reg;
    assign rsp.status      = status_reg;

    // A transfer always moves the sequencer to the response state.
    a_xfer_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == S_RESP))
        else $error("request transfer did not start a response");

    // An empty queue reports zero at both ends.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && empty_reg) |-> (front_reg == '0 && back_reg == '0))
        else $error("empty result carries nonzero end values");

    // A capacity of at least one can never be both empty and full.
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(empty_reg && full_reg))
        else $error("result flagged both empty and full");

    // Overflow leaves the queue full; underflow leaves it empty.
    a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((status_reg != STAT_OVERFLOW || full_reg)
                           && (status_reg != STAT_UNDERFLOW || empty_reg)))
        else $error("status code disagrees with the fill flags");

endmodule
